// File: hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, axis codes and pipeline payload types for the rotation
// matrix to quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

    // element and result format, signed q2.14
    localparam int E_W = 16;
    localparam int FX_ONE = 16384;

    // trace of four elements and pivot radicand before the sign test
    localparam int T_W = 19;
    // positive radicand, raw unsigned q4.14
    localparam int R_W = 18;
    // radicand is scaled by 2^FRAC_SHIFT before the square root
    localparam int FRAC_SHIFT = 30;
    // square root result, unsigned q.22
    localparam int S_W = 24;
    localparam int SQRT_STAGES = S_W;

    // numerator: sum or difference of two elements
    localparam int N_W = 17;
    // numerator scale factor 2^21
    localparam int NUM_SHIFT = 21;
    // scaled numerator plus rounding half
    localparam int A_W = 38;
    // quotient bits, one per divider stage
    localparam int Q_W = 23;
    localparam int DIV_STAGES = Q_W;

    // pivot axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // branch and error control that rides along with each word
    typedef struct packed {
        logic       direct;
        logic [1:0] piv;
        logic       bad;
    } ctrl_t;

    // sideband carried beside the square root
    typedef struct packed {
        ctrl_t                 ctrl;
        logic signed [N_W-1:0] n0;
        logic signed [N_W-1:0] n1;
        logic signed [N_W-1:0] n2;
    } sqrt_side_t;

    // sideband carried beside the dividers
    typedef struct packed {
        ctrl_t          ctrl;
        logic [2:0]     neg;
        logic [E_W-1:0] pv;
    } div_side_t;

endpackage

`default_nettype wire

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a q2.14 rotation matrix to a saturated quaternion.
// ----------------------------------------------------------------------------
// Takes one matrix word per clock while not stalled and returns one
// quaternion word per word, in order, through 51 register stages: the
// 24-stage square root (one root bit per stage) followed by three 23-stage
// dividers (one quotient bit per stage) working side by side, plus two
// front stages for the trace and pivot, one stage to form the dividends and
// the output register. The whole pipeline holds while a finished word is
// stalled at the output; src_stall follows res_stall of a waiting word.
`default_nettype none

module rotation_matrix_to_quaternion (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           src_valid,
    output logic                                src_stall,
    input  wire logic signed [rmq_pkg::E_W-1:0] m00,
    input  wire logic signed [rmq_pkg::E_W-1:0] m01,
    input  wire logic signed [rmq_pkg::E_W-1:0] m02,
    input  wire logic signed [rmq_pkg::E_W-1:0] m10,
    input  wire logic signed [rmq_pkg::E_W-1:0] m11,
    input  wire logic signed [rmq_pkg::E_W-1:0] m12,
    input  wire logic signed [rmq_pkg::E_W-1:0] m20,
    input  wire logic signed [rmq_pkg::E_W-1:0] m21,
    input  wire logic signed [rmq_pkg::E_W-1:0] m22,
    input  wire logic signed [rmq_pkg::E_W-1:0] m33,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output logic signed [rmq_pkg::E_W-1:0]      qx,
    output logic signed [rmq_pkg::E_W-1:0]      qy,
    output logic signed [rmq_pkg::E_W-1:0]      qz,
    output logic signed [rmq_pkg::E_W-1:0]      qw,
    output logic                                invalid
);
    import rmq_pkg::*;

    localparam int NUM_STAGES = 2 + SQRT_STAGES + 1 + DIV_STAGES + 1;
    localparam logic [E_W-1:0] POS_MAX = E_W'((1 << (E_W - 1)) - 1);
    localparam logic [E_W-1:0] NEG_MAX = E_W'(1 << (E_W - 1));

    // saturate a quotient magnitude with its sign
    function automatic logic [E_W-1:0] sat_lane(input logic [Q_W-1:0] q, input logic neg);
        logic [E_W-1:0] r;
        if (neg)
        begin
            if (q > Q_W'(NEG_MAX))
                r = NEG_MAX;
            else
                r = E_W'(~q[E_W-1:0] + 1'b1);
        end
        else
        begin
            if (q > Q_W'(POS_MAX))
                r = POS_MAX;
            else
                r = q[E_W-1:0];
        end
        return r;
    endfunction

    logic en;
    logic [NUM_STAGES-1:0] vld_reg;

    // pipeline advances unless the output word is held
    assign en        = !(vld_reg[NUM_STAGES-1] && res_stall);
    assign src_stall = !en;
    assign res_valid = vld_reg[NUM_STAGES-1];

    // valid bits travel with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], src_valid};
        end
    end

    // stage 1: trace and pivot axis
    logic signed [T_W-1:0] tr_next;
    logic [1:0]            piv_next;
    logic signed [E_W-1:0] d01;
    logic signed [T_W-1:0] tr_reg;
    logic [1:0]            piv_reg;
    logic signed [E_W-1:0] e00_reg, e01_reg, e02_reg, e10_reg, e11_reg;
    logic signed [E_W-1:0] e12_reg, e20_reg, e21_reg, e22_reg;

    always_comb
    begin
        tr_next = T_W'(m00) + T_W'(m11) + T_W'(m22) + T_W'(m33);
        d01 = (m00 <= m11) ? m11 : m00;
        if (m22 > d01)
            piv_next = AXIS_Z;
        else if (m00 <= m11)
            piv_next = AXIS_Y;
        else
            piv_next = AXIS_X;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tr_reg  <= tr_next;
            piv_reg <= piv_next;
            e00_reg <= m00;
            e01_reg <= m01;
            e02_reg <= m02;
            e10_reg <= m10;
            e11_reg <= m11;
            e12_reg <= m12;
            e20_reg <= m20;
            e21_reg <= m21;
            e22_reg <= m22;
        end
    end

    // stage 2: radicand, branch and numerators
    logic signed [T_W-1:0] ii, jj, kk, rad_s;
    logic [R_W-1:0]        rad_next;
    sqrt_side_t            sb_next;
    logic [R_W-1:0]        rad_reg;
    sqrt_side_t            sb2_reg;

    always_comb
    begin
        sb_next.ctrl.piv    = piv_reg;
        sb_next.ctrl.direct = tr_reg >= T_W'(FX_ONE);
        case (piv_reg)
            AXIS_Y:
            begin
                ii = T_W'(e11_reg); jj = T_W'(e22_reg); kk = T_W'(e00_reg);
                sb_next.n0 = N_W'(e21_reg) + N_W'(e12_reg);
                sb_next.n1 = N_W'(e01_reg) + N_W'(e10_reg);
                sb_next.n2 = N_W'(e20_reg) - N_W'(e02_reg);
            end
            AXIS_Z:
            begin
                ii = T_W'(e22_reg); jj = T_W'(e00_reg); kk = T_W'(e11_reg);
                sb_next.n0 = N_W'(e02_reg) + N_W'(e20_reg);
                sb_next.n1 = N_W'(e12_reg) + N_W'(e21_reg);
                sb_next.n2 = N_W'(e01_reg) - N_W'(e10_reg);
            end
            default:
            begin
                ii = T_W'(e00_reg); jj = T_W'(e11_reg); kk = T_W'(e22_reg);
                sb_next.n0 = N_W'(e10_reg) + N_W'(e01_reg);
                sb_next.n1 = N_W'(e20_reg) + N_W'(e02_reg);
                sb_next.n2 = N_W'(e12_reg) - N_W'(e21_reg);
            end
        endcase
        rad_s = ii - jj - kk + T_W'(FX_ONE);
        if (sb_next.ctrl.direct)
        begin
            sb_next.n0  = N_W'(e12_reg) - N_W'(e21_reg);
            sb_next.n1  = N_W'(e20_reg) - N_W'(e02_reg);
            sb_next.n2  = N_W'(e01_reg) - N_W'(e10_reg);
            sb_next.ctrl.bad = 1'b0;
            rad_next    = R_W'(tr_reg);
        end
        else
        begin
            sb_next.ctrl.bad = rad_s <= 0;
            rad_next    = R_W'(rad_s);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= rad_next;
            sb2_reg <= sb_next;
        end
    end

    // square root with sideband alongside
    logic [S_W-1:0] root;
    sqrt_side_t     sq_sb_reg [SQRT_STAGES];

    rmq_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_sb_reg[0] <= sb2_reg;
            for (int s = 1; s < SQRT_STAGES; s++)
                sq_sb_reg[s] <= sq_sb_reg[s-1];
        end
    end

    // dividend prep: |n| scaled plus half the divisor, and pivot component
    sqrt_side_t     sq_out;
    logic [N_W-1:0] mag0, mag1, mag2;
    logic [S_W:0]   pv_sum;
    logic [A_W-1:0] a0_reg, a1_reg, a2_reg;
    logic [S_W-1:0] den_reg;
    div_side_t      pp_sb_next;
    div_side_t      pp_sb_reg;

    assign sq_out = sq_sb_reg[SQRT_STAGES-1];

    always_comb
    begin
        mag0 = sq_out.n0[N_W-1] ? N_W'(-sq_out.n0) : N_W'(sq_out.n0);
        mag1 = sq_out.n1[N_W-1] ? N_W'(-sq_out.n1) : N_W'(sq_out.n1);
        mag2 = sq_out.n2[N_W-1] ? N_W'(-sq_out.n2) : N_W'(sq_out.n2);
        pv_sum = {1'b0, root} + (S_W+1)'(256);
        pp_sb_next.ctrl = sq_out.ctrl;
        pp_sb_next.neg  = {sq_out.n2[N_W-1], sq_out.n1[N_W-1], sq_out.n0[N_W-1]};
        if (pv_sum[S_W:9] > (S_W-8)'(POS_MAX))
            pp_sb_next.pv = POS_MAX;
        else
            pp_sb_next.pv = pv_sum[E_W+8:9];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg    <= (A_W'(mag0) << NUM_SHIFT) + A_W'(root >> 1);
            a1_reg    <= (A_W'(mag1) << NUM_SHIFT) + A_W'(root >> 1);
            a2_reg    <= (A_W'(mag2) << NUM_SHIFT) + A_W'(root >> 1);
            den_reg   <= root;
            pp_sb_reg <= pp_sb_next;
        end
    end

    // three divider lanes
    logic [Q_W-1:0] quo0, quo1, quo2;
    div_side_t      dv_sb_reg [DIV_STAGES];

    rmq_div u_div0 (.clk(clk), .en(en), .num(a0_reg), .den(den_reg), .quo(quo0));
    rmq_div u_div1 (.clk(clk), .en(en), .num(a1_reg), .den(den_reg), .quo(quo1));
    rmq_div u_div2 (.clk(clk), .en(en), .num(a2_reg), .den(den_reg), .quo(quo2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_sb_reg[0] <= pp_sb_reg;
            for (int s = 1; s < DIV_STAGES; s++)
                dv_sb_reg[s] <= dv_sb_reg[s-1];
        end
    end

    // output stage: sign, saturate and place components
    div_side_t      dv_out;
    logic [E_W-1:0] l0, l1, l2;
    logic [E_W-1:0] qx_next, qy_next, qz_next, qw_next;
    logic [E_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic           invalid_reg;

    assign dv_out = dv_sb_reg[DIV_STAGES-1];

    always_comb
    begin
        l0 = sat_lane(quo0, dv_out.neg[0]);
        l1 = sat_lane(quo1, dv_out.neg[1]);
        l2 = sat_lane(quo2, dv_out.neg[2]);
        if (dv_out.ctrl.bad)
        begin
            qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
        end
        else if (dv_out.ctrl.direct)
        begin
            qx_next = l0; qy_next = l1; qz_next = l2; qw_next = dv_out.pv;
        end
        else
        begin
            qw_next = l2;
            case (dv_out.ctrl.piv)
                AXIS_Y:
                begin
                    qx_next = l1; qy_next = dv_out.pv; qz_next = l0;
                end
                AXIS_Z:
                begin
                    qx_next = l0; qy_next = l1; qz_next = dv_out.pv;
                end
                default:
                begin
                    qx_next = dv_out.pv; qy_next = l0; qz_next = l1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg      <= qx_next;
            qy_reg      <= qy_next;
            qz_reg      <= qz_next;
            qw_reg      <= qw_next;
            invalid_reg <= dv_out.ctrl.bad;
        end
    end

    assign qx      = qx_reg;
    assign qy      = qy_reg;
    assign qz      = qz_reg;
    assign qw      = qw_reg;
    assign invalid = invalid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rmq_isqrt.sv
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined integer square root of rad * 2^30, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_isqrt (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [rmq_pkg::R_W-1:0] rad,
    output logic      [rmq_pkg::S_W-1:0] root
);
    import rmq_pkg::*;

    // stages that still consume nonzero radicand bits
    localparam int RAD_STAGES = SQRT_STAGES - FRAC_SHIFT / 2;

    logic [R_W-1:0] rad_reg  [RAD_STAGES-1];
    logic [S_W:0]   rem_reg  [SQRT_STAGES-1];
    logic [S_W-1:0] root_reg [SQRT_STAGES];

    for (genvar t = 0; t < SQRT_STAGES; t++) begin : g_stage
        localparam int P = SQRT_STAGES - 1 - t;

        logic [1:0]     pair;
        logic [S_W:0]   rem_in;
        logic [S_W-1:0] root_in;
        logic [S_W+2:0] cur;
        logic [S_W+2:0] trial;
        logic           ge;

        // previous partial root and remainder
        if (t == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else begin : g_next
            assign rem_in  = rem_reg[t-1];
            assign root_in = root_reg[t-1];
        end

        // next two radicand bits
        if (P >= FRAC_SHIFT / 2) begin : g_pair
            if (t == 0) begin : g_src_in
                assign pair = rad[2*P+1-FRAC_SHIFT -: 2];
            end
            else begin : g_src_reg
                assign pair = rad_reg[t-1][2*P+1-FRAC_SHIFT -: 2];
            end
        end
        else begin : g_zero
            assign pair = 2'b00;
        end

        // trial subtract of 4*root+1
        assign cur   = {rem_in, pair};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[t] <= {root_in[S_W-2:0], ge};
            end
        end

        if (t < SQRT_STAGES - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[t] <= ge ? (S_W+1)'(cur - trial) : (S_W+1)'(cur);
                end
            end
        end

        if (t < RAD_STAGES - 1) begin : g_rad
            if (t == 0) begin : g_rad_in
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rad_reg[t] <= rad;
                    end
                end
            end
            else begin : g_rad_shift
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rad_reg[t] <= rad_reg[t-1];
                    end
                end
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [rmq_pkg::A_W-1:0] num,
    input  wire logic [rmq_pkg::S_W-1:0] den,
    output logic      [rmq_pkg::Q_W-1:0] quo
);
    import rmq_pkg::*;

    logic [S_W-1:0] rem_reg [DIV_STAGES-1];
    logic [S_W-1:0] den_reg [DIV_STAGES-1];
    logic [Q_W-1:0] lo_reg  [DIV_STAGES-1];
    logic [Q_W-1:0] quo_reg [DIV_STAGES];

    for (genvar t = 0; t < DIV_STAGES; t++) begin : g_stage
        logic [S_W-1:0] rem_in;
        logic [S_W-1:0] den_in;
        logic [Q_W-1:0] lo_in;
        logic [Q_W-1:0] quo_in;
        logic [S_W:0]   cur;
        logic           ge;

        // top numerator bits seed the remainder
        if (t == 0) begin : g_first
            assign rem_in = S_W'(num[A_W-1:Q_W]);
            assign den_in = den;
            assign lo_in  = num[Q_W-1:0];
            assign quo_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[t-1];
            assign den_in = den_reg[t-1];
            assign lo_in  = lo_reg[t-1];
            assign quo_in = quo_reg[t-1];
        end

        // shift in one numerator bit and trial subtract
        assign cur = {rem_in, lo_in[Q_W-1-t]};
        assign ge  = cur >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[t] <= {quo_in[Q_W-2:0], ge};
            end
        end

        if (t < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[t] <= ge ? S_W'(cur - {1'b0, den_in}) : S_W'(cur);
                    den_reg[t] <= den_in;
                    lo_reg[t]  <= lo_in;
                end
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the quaternion converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           src_stall,
    input wire logic                           res_valid,
    input wire logic                           res_stall,
    input wire logic signed [rmq_pkg::E_W-1:0] qx,
    input wire logic signed [rmq_pkg::E_W-1:0] qy,
    input wire logic signed [rmq_pkg::E_W-1:0] qz,
    input wire logic signed [rmq_pkg::E_W-1:0] qw,
    input wire logic                           invalid
);
    // a held word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(qx) && $stable(qy)
            && $stable(qz) && $stable(qw) && $stable(invalid))
        else $error("result word changed while stalled");

    // a bad radicand gives an all-zero quaternion
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && invalid |-> qx == 0 && qy == 0 && qz == 0 && qw == 0)
        else $error("invalid word with nonzero components");

    // input backs up only behind a held result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> res_valid && res_stall)
        else $error("input stalled without a held result");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_stall (src_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .qx        (qx),
    .qy        (qy),
    .qz        (qz),
    .qw        (qw),
    .invalid   (invalid)
);

`default_nettype wire

// File: sim/rotation_matrix_to_quaternion_test.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Drives matrix words into the quaternion converter with random gaps and
// output stalls, predicts each quaternion in fixed point and compares every
// returned word field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_test;

    import rmq_pkg::*;

    typedef logic signed [E_W-1:0] elem_t;

    typedef struct {
        elem_t m [0:9];
    } matrix_t;

    typedef struct {
        elem_t x;
        elem_t y;
        elem_t z;
        elem_t w;
        logic  bad;
    } quat_t;

    // fixed point prediction of one conversion
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic elem_t clip16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return elem_t'(v);
    endfunction

    function automatic elem_t scaled_quotient(longint num, longint unsigned s);
        longint d;
        longint n;
        longint q;
        d = longint'(s);
        n = num * 2097152;
        if (n >= 0)
            q = (n + d / 2) / d;
        else
            q = -((-n + d / 2) / d);
        return clip16(q);
    endfunction

    function automatic quat_t matrix_to_quat(matrix_t a);
        longint e [0:2][0:2];
        longint tr;
        longint rad;
        longint unsigned s;
        elem_t q [0:3];
        int i;
        int j;
        int k;
        quat_t o;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                e[r][c] = a.m[r*3+c];
        for (int n = 0; n < 4; n++)
            q[n] = '0;
        o.bad = 1'b0;
        tr = e[0][0] + e[1][1] + e[2][2] + longint'(a.m[9]);
        if (tr >= FX_ONE)
        begin
            s = int_sqrt(longint'(tr) << 30);
            q[0] = scaled_quotient(e[1][2] - e[2][1], s);
            q[1] = scaled_quotient(e[2][0] - e[0][2], s);
            q[2] = scaled_quotient(e[0][1] - e[1][0], s);
            q[3] = clip16(longint'((s + 256) >> 9));
        end
        else
        begin
            i = AXIS_X;
            if (e[0][0] <= e[1][1])
                i = AXIS_Y;
            if (e[2][2] > e[i][i])
                i = AXIS_Z;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            rad = e[i][i] - e[j][j] - e[k][k] + FX_ONE;
            if (rad <= 0)
                o.bad = 1'b1;
            else
            begin
                s = int_sqrt(longint'(rad) << 30);
                q[i] = clip16(longint'((s + 256) >> 9));
                q[j] = scaled_quotient(e[j][i] + e[i][j], s);
                q[k] = scaled_quotient(e[k][i] + e[i][k], s);
                q[3] = scaled_quotient(e[j][k] - e[k][j], s);
            end
        end
        o.x = q[0];
        o.y = q[1];
        o.z = q[2];
        o.w = q[3];
        return o;
    endfunction

    // expected quaternions in order, and the comparison
    class quat_scoreboard;
        quat_t pending [$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        function void note_matrix(matrix_t a);
            pending.push_back(matrix_to_quat(a));
        endfunction

        function void check_quat(quat_t got);
            quat_t exp_q;
            if (pending.size() == 0)
            begin
                $error("unexpected quaternion word");
                errors++;
                return;
            end
            exp_q = pending.pop_front();
            if (got.x !== exp_q.x)
            begin
                $error("qx expected %0d actual %0d", exp_q.x, got.x);
                errors++;
            end
            if (got.y !== exp_q.y)
            begin
                $error("qy expected %0d actual %0d", exp_q.y, got.y);
                errors++;
            end
            if (got.z !== exp_q.z)
            begin
                $error("qz expected %0d actual %0d", exp_q.z, got.z);
                errors++;
            end
            if (got.w !== exp_q.w)
            begin
                $error("qw expected %0d actual %0d", exp_q.w, got.w);
                errors++;
            end
            if (got.bad !== exp_q.bad)
            begin
                $error("invalid expected %0b actual %0b", exp_q.bad, got.bad);
                errors++;
            end
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  src_valid = 1'b0;
    logic  src_stall;
    elem_t m [0:9] = '{default: '0};
    logic  res_valid;
    logic  res_stall = 1'b0;
    elem_t qx;
    elem_t qy;
    elem_t qz;
    elem_t qw;
    logic  invalid;

    logic  hold_off = 1'b0;
    bit    send_done = 1'b0;

    quat_scoreboard board = new();

    always #5 clk = ~clk;

    rotation_matrix_to_quaternion i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .m00       (m[0]),
        .m01       (m[1]),
        .m02       (m[2]),
        .m10       (m[3]),
        .m11       (m[4]),
        .m12       (m[5]),
        .m20       (m[6]),
        .m21       (m[7]),
        .m22       (m[8]),
        .m33       (m[9]),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .qx        (qx),
        .qy        (qy),
        .qz        (qz),
        .qw        (qw),
        .invalid   (invalid)
    );

    // mostly short gaps, a few long ones, many runs with none
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one matrix word and wait for it to be taken
    task automatic send_matrix(matrix_t a);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            src_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        src_valid <= 1'b1;
        for (int n = 0; n < 10; n++)
            m[n] <= a.m[n];
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        board.note_matrix(a);
    endtask

    function automatic elem_t rand_elem();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return -16'sd32768;
        if (p == 1)
            return 16'sd32767;
        if (p < 5)
            return elem_t'($urandom_range(0, 32768) - 16384);
        return elem_t'($urandom());
    endfunction

    function automatic matrix_t fill_matrix(int d, int off);
        matrix_t a;
        for (int n = 0; n < 10; n++)
            a.m[n] = elem_t'(off);
        a.m[0] = elem_t'(d);
        a.m[4] = elem_t'(d);
        a.m[8] = elem_t'(d);
        return a;
    endfunction

    // turns about x, y or z from cosine c and sine s, and near-rotation content
    function automatic matrix_t rotation_like(int axis, int c, int s);
        matrix_t a;
        a = fill_matrix(0, 0);
        a.m[9] = 16'sd16384;
        a.m[axis*4] = 16'sd16384;
        a.m[((axis+1)%3)*4] = elem_t'(c);
        a.m[((axis+2)%3)*4] = elem_t'(c);
        a.m[((axis+1)%3)*3 + (axis+2)%3] = elem_t'(s);
        a.m[((axis+2)%3)*3 + (axis+1)%3] = elem_t'(-s);
        return a;
    endfunction

    // directed words then random ones
    initial
    begin
        matrix_t a;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // identity, zero, extremes, each pivot axis
        send_matrix(rotation_like(0, 16384, 0));
        send_matrix(fill_matrix(0, 0));
        send_matrix(fill_matrix(32767, 32767));
        send_matrix(fill_matrix(-32768, -32768));
        send_matrix(fill_matrix(32767, -32768));
        send_matrix(fill_matrix(-32768, 32767));
        for (int ax = 0; ax < 3; ax++)
        begin
            send_matrix(rotation_like(ax, -16384, 0));
            send_matrix(rotation_like(ax, 0, 16384));
            send_matrix(rotation_like(ax, 11585, -11585));
        end
        // pivot x and pivot y words with extreme off-diagonal elements
        a = fill_matrix(-16384, 32767);
        a.m[0] = 16'sd1;
        a.m[9] = 16'sd0;
        send_matrix(a);
        a = fill_matrix(-8192, -32768);
        a.m[9] = 16'sd0;
        send_matrix(a);
        // ties among diagonals
        a = fill_matrix(-4000, 1234);
        a.m[9] = -16'sd4000;
        send_matrix(a);
        // trace exactly one and just below
        a = fill_matrix(0, 777);
        a.m[9] = 16'sd16384;
        send_matrix(a);
        a.m[9] = 16'sd16383;
        send_matrix(a);
        // direct branch with overflowing numerators
        a = fill_matrix(16384, 0);
        a.m[9] = 16'sd16384;
        a.m[5] = 16'sd32767;
        a.m[7] = -16'sd32768;
        send_matrix(a);
        for (int it = 0; it < 1650; it++)
        begin
            if (it % 3 == 0)
                a = rotation_like($urandom_range(0, 2), $urandom_range(0, 32768) - 16384,
                                  $urandom_range(0, 32768) - 16384);
            else
                for (int n = 0; n < 10; n++)
                    a.m[n] = rand_elem();
            send_matrix(a);
        end
        src_valid <= 1'b0;
        send_done = 1'b1;
    end

    // long receiver hold-off once, early in the random part
    initial
    begin
        repeat (200) @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // receiver stalls
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            res_stall <= (g > 0) || hold_off;
            repeat (g > 0 ? g : 1) @(posedge clk);
            while (hold_off)
            begin
                res_stall <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // collect result words
    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            board.check_quat('{x: qx, y: qy, z: qz, w: qw, bad: invalid});

    // end of run
    initial
    begin
        wait (send_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("rotation_matrix_to_quaternion_test OK");
        else
            $display("rotation_matrix_to_quaternion_test NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("rotation_matrix_to_quaternion_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
